// ===== rtl/core/dcfg_pkg.sv =====
// ----------------------------------------------------------------------------
// dcfg_pkg
// Shared types and constants of the downlink configuration record parser.
// ----------------------------------------------------------------------------
package dcfg_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TAG_ACK      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_DNS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_FLASH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_TIME     = 3'd4;

    localparam logic [7:0] RST_TAG_ACK      = 8'd1;
    localparam logic [7:0] RST_TAG_INTERVAL = 8'd2;
    localparam logic [7:0] RST_TAG_DNS      = 8'd3;
    localparam logic [7:0] RST_TAG_FLASH    = 8'd4;
    localparam logic [7:0] RST_TAG_TIME     = 8'd5;

    localparam logic [2:0] LEN_ACK      = 3'd4;
    localparam logic [2:0] LEN_INTERVAL = 3'd2;
    localparam logic [2:0] LEN_DNS      = 3'd1;
    localparam logic [2:0] LEN_WORD     = 3'd4;

    typedef enum logic [2:0] {
        KIND_TYPE     = 3'd0,
        KIND_ACK      = 3'd1,
        KIND_INTERVAL = 3'd2,
        KIND_DNS      = 3'd3,
        KIND_FLASH    = 3'd4,
        KIND_TIME     = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_INVALID   = 2'd2,
        ST_UNKNOWN   = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] ack;
        logic [7:0] interval;
        logic [7:0] dns;
        logic [7:0] flash;
        logic [7:0] time_stamp;
    } t_tags;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  bytes_left;
        logic [31:0] gather;
        t_status     error;
    } t_parse;

    typedef struct packed {
        logic [31:0] acked;
        logic [7:0]  interval;
        logic [7:0]  multiplier;
        logic        server;
        logic [31:0] flash;
        logic [31:0] time_stamp;
    } t_values;

endpackage

// ===== rtl/core/downlink_config_tlv_parser_core.sv =====
// ----------------------------------------------------------------------------
// downlink_config_tlv_parser_core
// Byte-wide parser of type-tagged downlink configuration records.
// ----------------------------------------------------------------------------
// One payload byte is taken per cycle while the result side keeps up. A byte
// marked last yields one result in the next cycle: the packet status and the
// committed values, held until taken. While a result is still unclaimed no
// further byte is taken, so a stalled result side stalls the byte side; the
// single result register sets that stall. Tag registers are written through
// the config port and take effect at the next type byte.
module downlink_config_tlv_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dcfg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_status,
    output logic [31:0]                    o_acked_sequence,
    output logic [7:0]                     o_report_interval,
    output logic [7:0]                     o_period_multiplier,
    output logic                           o_server_id,
    output logic [31:0]                    o_flash_position,
    output logic [31:0]                    o_last_timestamp
);

    dcfg_pkg::t_tags   r_tags;
    dcfg_pkg::t_parse  r_parse;
    dcfg_pkg::t_parse  n_parse;
    dcfg_pkg::t_values r_shadow;
    dcfg_pkg::t_values n_shadow;
    dcfg_pkg::t_values r_commit;
    dcfg_pkg::t_values shadow_eff;
    dcfg_pkg::t_status n_status;
    dcfg_pkg::t_status r_status;
    logic              r_mid;
    logic              r_out_valid;
    logic              commit;
    logic              accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign accept      = i_valid && o_ready;
    assign shadow_eff  = r_mid ? r_shadow : r_commit;

    dcfg_byte_step u_step (
        .i_tags      (r_tags),
        .i_parse     (r_parse),
        .i_shadow    (shadow_eff),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_parse     (n_parse),
        .o_shadow    (n_shadow),
        .o_status    (n_status),
        .o_commit    (commit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tags.ack        <= dcfg_pkg::RST_TAG_ACK;
            r_tags.interval   <= dcfg_pkg::RST_TAG_INTERVAL;
            r_tags.dns        <= dcfg_pkg::RST_TAG_DNS;
            r_tags.flash      <= dcfg_pkg::RST_TAG_FLASH;
            r_tags.time_stamp <= dcfg_pkg::RST_TAG_TIME;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dcfg_pkg::CFG_TAG_ACK:      r_tags.ack        <= i_cfg_data;
                dcfg_pkg::CFG_TAG_INTERVAL: r_tags.interval   <= i_cfg_data;
                dcfg_pkg::CFG_TAG_DNS:      r_tags.dns        <= i_cfg_data;
                dcfg_pkg::CFG_TAG_FLASH:    r_tags.flash      <= i_cfg_data;
                dcfg_pkg::CFG_TAG_TIME:     r_tags.time_stamp <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse.kind       <= dcfg_pkg::KIND_TYPE;
            r_parse.bytes_left <= 3'd0;
            r_parse.gather     <= '0;
            r_parse.error      <= dcfg_pkg::ST_OK;
            r_mid              <= 1'b0;
            r_commit           <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            if (accept) begin
                if (i_last_byte) begin
                    r_parse.kind       <= dcfg_pkg::KIND_TYPE;
                    r_parse.bytes_left <= 3'd0;
                    r_parse.gather     <= '0;
                    r_parse.error      <= dcfg_pkg::ST_OK;
                    r_mid              <= 1'b0;
                end else begin
                    r_parse <= n_parse;
                    r_mid   <= 1'b1;
                end
                if (commit) r_commit <= n_shadow;
            end
            if (accept && i_last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_shadow <= n_shadow;
            if (i_last_byte) r_status <= n_status;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_status;
    assign o_acked_sequence    = r_commit.acked;
    assign o_report_interval   = r_commit.interval;
    assign o_period_multiplier = r_commit.multiplier;
    assign o_server_id         = r_commit.server;
    assign o_flash_position    = r_commit.flash;
    assign o_last_timestamp    = r_commit.time_stamp;

endmodule

// ===== rtl/core/dcfg_byte_step.sv =====
// ----------------------------------------------------------------------------
// dcfg_byte_step
// Next parse state, shadow values and packet status for one payload byte.
// ----------------------------------------------------------------------------
module dcfg_byte_step (
    input  dcfg_pkg::t_tags   i_tags,
    input  dcfg_pkg::t_parse  i_parse,
    input  dcfg_pkg::t_values i_shadow,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output dcfg_pkg::t_parse  o_parse,
    output dcfg_pkg::t_values o_shadow,
    output dcfg_pkg::t_status o_status,
    output logic              o_commit
);

    logic [31:0] gathered;
    logic [2:0]  left_dec;

    assign gathered = {i_data_byte, i_parse.gather[31:8]};
    assign left_dec = (i_parse.bytes_left != 3'd0) ? (i_parse.bytes_left - 3'd1)
                                                   : i_parse.bytes_left;

    always_comb begin
        o_parse  = i_parse;
        o_shadow = i_shadow;
        if (i_parse.error == dcfg_pkg::ST_OK) begin
            if (i_parse.kind == dcfg_pkg::KIND_TYPE) begin
                o_parse.gather = '0;
                if (i_data_byte == i_tags.ack) begin
                    o_parse.kind       = dcfg_pkg::KIND_ACK;
                    o_parse.bytes_left = dcfg_pkg::LEN_ACK;
                end else if (i_data_byte == i_tags.interval) begin
                    o_parse.kind       = dcfg_pkg::KIND_INTERVAL;
                    o_parse.bytes_left = dcfg_pkg::LEN_INTERVAL;
                end else if (i_data_byte == i_tags.dns) begin
                    o_parse.kind       = dcfg_pkg::KIND_DNS;
                    o_parse.bytes_left = dcfg_pkg::LEN_DNS;
                end else if (i_data_byte == i_tags.flash) begin
                    o_parse.kind       = dcfg_pkg::KIND_FLASH;
                    o_parse.bytes_left = dcfg_pkg::LEN_WORD;
                end else if (i_data_byte == i_tags.time_stamp) begin
                    o_parse.kind       = dcfg_pkg::KIND_TIME;
                    o_parse.bytes_left = dcfg_pkg::LEN_WORD;
                end else begin
                    o_parse.kind       = dcfg_pkg::KIND_TYPE;
                    o_parse.bytes_left = 3'd0;
                    o_parse.error      = dcfg_pkg::ST_UNKNOWN;
                end
            end else begin
                o_parse.gather     = gathered;
                o_parse.bytes_left = left_dec;
                case (i_parse.kind)
                    dcfg_pkg::KIND_INTERVAL: begin
                        if (left_dec == 3'd1) begin
                            o_shadow.interval = i_data_byte;
                        end else begin
                            o_shadow.multiplier = i_data_byte;
                        end
                    end
                    dcfg_pkg::KIND_DNS: begin
                        if (i_data_byte > 8'd1) begin
                            o_parse.error = dcfg_pkg::ST_INVALID;
                        end else begin
                            o_shadow.server = i_data_byte[0];
                        end
                    end
                    dcfg_pkg::KIND_ACK: begin
                        if (left_dec == 3'd0) o_shadow.acked = gathered;
                    end
                    dcfg_pkg::KIND_FLASH: begin
                        if (left_dec == 3'd0) o_shadow.flash = gathered;
                    end
                    dcfg_pkg::KIND_TIME: begin
                        if (left_dec == 3'd0) o_shadow.time_stamp = gathered;
                    end
                    default: begin
                    end
                endcase
                if (left_dec == 3'd0) o_parse.kind = dcfg_pkg::KIND_TYPE;
            end
        end
    end

    always_comb begin
        o_status = o_parse.error;
        if (i_last_byte && (o_parse.error == dcfg_pkg::ST_OK)
                && (o_parse.kind != dcfg_pkg::KIND_TYPE)) begin
            o_status = dcfg_pkg::ST_TRUNCATED;
        end
        o_commit = i_last_byte && (o_status == dcfg_pkg::ST_OK);
    end

endmodule
